// ===== hdl/rmv_pkg.sv =====
package rmv_pkg;

  // Default parameter values
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COUNT_WIDTH_DEF  = 32;
  localparam int FRAC_BITS_DEF    = 16;

  // Result field widths
  localparam int COUNT_OUT_W = 32;
  localparam int MINMAX_W    = 16;
  localparam int MEAN_W      = 32;
  localparam int VAR_W       = 47;
  localparam int STD_W       = 23;

  // Datapath of the shared unit
  localparam int DATA_W    = 64;
  localparam int STEP_W    = 7;
  localparam int VAR_FRAC  = 16;
  localparam int ROOT_W    = DATA_W / 2;

  // Operations of the shared unit
  typedef enum logic [1:0] {
    OP_DIV,
    OP_MUL,
    OP_SQRT
  } rmv_op_t;

  // Request to the shared unit
  typedef struct packed {
    logic    start;
    rmv_op_t op;
  } rmv_req_t;

endpackage

// ===== hdl/rmv_intf.sv =====
// Sample channel
interface rmv_in_if #(
  parameter int SAMPLE_WIDTH = rmv_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// Statistics result channel
interface rmv_out_if;
  logic                                   valid;
  logic                                   ready;
  logic        [rmv_pkg::COUNT_OUT_W-1:0] sample_count;
  logic signed [rmv_pkg::MINMAX_W-1:0]    min_value;
  logic signed [rmv_pkg::MINMAX_W-1:0]    max_value;
  logic signed [rmv_pkg::MEAN_W-1:0]      mean_value;
  logic        [rmv_pkg::VAR_W-1:0]       variance_value;
  logic        [rmv_pkg::STD_W-1:0]       std_deviation;

  modport source (output valid, output sample_count, output min_value, output max_value,
                  output mean_value, output variance_value, output std_deviation,
                  input ready);
  modport sink   (input valid, input sample_count, input min_value, input max_value,
                  input mean_value, input variance_value, input std_deviation,
                  output ready);
endinterface

// ===== hdl/running_mean_variance_min_max_unit.sv =====
// Each sample runs through the shared unit in order: mean divide, product, variance divide
// and square root, then one output load, plus any wait for the output register; the first
// sample skips the mean divide and product.
// One sample is in work at a time; in_ready is low while a sample is in work.
// Reset (synchronous, rst_n low) clears count, mean, spread sum, min and max to zero.
module running_mean_variance_min_max_unit #(
  parameter int SAMPLE_WIDTH = rmv_pkg::SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH  = rmv_pkg::COUNT_WIDTH_DEF,
  parameter int FRAC_BITS    = rmv_pkg::FRAC_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  rmv_in_if.sink      in_ch,
  rmv_out_if.source   out_ch
);

  localparam int DW  = rmv_pkg::DATA_W;
  localparam int XQW = SAMPLE_WIDTH + FRAC_BITS;
  localparam int MW  = XQW + 1;
  localparam int VAR_SHIFT = rmv_pkg::VAR_FRAC - FRAC_BITS;

  typedef enum logic [2:0] {S_IDLE, S_DIVM, S_MUL, S_DIVV, S_SQRT, S_OUT} state_t;

  state_t                           state_r;
  logic        [COUNT_WIDTH-1:0]    count_r;
  logic signed [XQW-1:0]            mean_r;
  logic        [DW-1:0]             sum_r;
  logic signed [SAMPLE_WIDTH-1:0]   min_r, max_r;
  logic signed [XQW-1:0]            xq_r;
  logic                             neg_r;
  logic        [MW-1:0]             d1mag_r;
  logic        [rmv_pkg::VAR_W-1:0] var_r;
  logic        [rmv_pkg::STD_W-1:0] sd_r;
  rmv_pkg::rmv_req_t                req_r, req_nxt;
  logic        [DW-1:0]             opa_r, opb_r;
  logic                             u_done;
  logic        [DW-1:0]             u_result;

  logic signed [XQW-1:0]            xq_in;
  logic signed [MW-1:0]             d1, nm, delta, d2;
  logic        [MW-1:0]             qt, d2mag;
  logic        [DW:0]               sum_add;
  logic        [rmv_pkg::VAR_W-1:0] var_nxt;
  logic        [rmv_pkg::STD_W-1:0] sd_nxt;

  rmv_iter_unit #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .FRAC_BITS   (FRAC_BITS),
    .MUL_WIDTH   (MW)
  ) u_iter (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req_r),
    .opa    (opa_r),
    .opb    (opb_r),
    .done   (u_done),
    .result (u_result)
  );

  // Datapath between unit operations
  always_comb begin
    xq_in   = {in_ch.sample, {FRAC_BITS{1'b0}}};
    d1      = MW'(xq_in) - MW'(mean_r);
    qt      = u_result[MW-1:0];
    delta   = neg_r ? -signed'(qt) : signed'(qt);
    nm      = MW'(mean_r) + delta;
    d2      = MW'(xq_r) - nm;
    d2mag   = d2[MW-1] ? MW'(-d2) : MW'(d2);
    sum_add = {1'b0, sum_r} + {1'b0, u_result};
    var_nxt = (|u_result[DW-1:rmv_pkg::VAR_W]) ? '1 : u_result[rmv_pkg::VAR_W-1:0];
    sd_nxt  = (|u_result[DW-1:rmv_pkg::STD_W]) ? '1 : u_result[rmv_pkg::STD_W-1:0];
  end

  // Start pulses to the shared unit
  always_comb begin
    req_nxt = '{start: 1'b0, op: rmv_pkg::OP_DIV};
    unique case (state_r)
      S_IDLE: if (in_ch.valid) req_nxt = '{start: 1'b1, op: rmv_pkg::OP_DIV};
      S_DIVM: if (u_done) req_nxt = '{start: 1'b1, op: rmv_pkg::OP_MUL};
      S_MUL:  if (u_done) req_nxt = '{start: 1'b1, op: rmv_pkg::OP_DIV};
      S_DIVV: if (u_done) req_nxt = '{start: 1'b1, op: rmv_pkg::OP_SQRT};
      default: ;
    endcase
  end

  assign in_ch.ready = (state_r == S_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      mean_r       <= '0;
      sum_r        <= '0;
      min_r        <= '0;
      max_r        <= '0;
      req_r        <= '{start: 1'b0, op: rmv_pkg::OP_DIV};
      out_ch.valid <= 1'b0;
    end else begin
      req_r <= req_nxt;
      // Output valid: set on load from S_OUT, cleared on transaction
      if (state_r == S_OUT && (!out_ch.valid || out_ch.ready)) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            xq_r <= xq_in;
            if (count_r == '0) begin
              count_r <= COUNT_WIDTH'(1);
              mean_r  <= xq_in;
              sum_r   <= '0;
              min_r   <= in_ch.sample;
              max_r   <= in_ch.sample;
              opb_r   <= '0;
              opa_r   <= DW'(1);
              state_r <= S_DIVV;
            end else begin
              if (count_r != '1) begin
                count_r <= count_r + 1'b1;
                opa_r   <= DW'(count_r + 1'b1);
              end else begin
                opa_r   <= DW'(count_r);
              end
              if (in_ch.sample < min_r) min_r <= in_ch.sample;
              if (in_ch.sample > max_r) max_r <= in_ch.sample;
              neg_r   <= d1[MW-1];
              d1mag_r <= d1[MW-1] ? MW'(-d1) : MW'(d1);
              opb_r   <= DW'(d1[MW-1] ? MW'(-d1) : MW'(d1));
              state_r <= S_DIVM;
            end
          end
        end
        S_DIVM: begin
          if (u_done) begin
            mean_r  <= XQW'(nm);
            opa_r   <= DW'(d1mag_r);
            opb_r   <= DW'(d2mag);
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (u_done) begin
            sum_r   <= sum_add[DW] ? '1 : sum_add[DW-1:0];
            opb_r   <= sum_add[DW] ? '1 : sum_add[DW-1:0];
            opa_r   <= DW'(count_r);
            state_r <= S_DIVV;
          end
        end
        S_DIVV: begin
          if (u_done) begin
            var_r   <= var_nxt;
            opb_r   <= DW'(var_nxt) << VAR_SHIFT;
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (u_done) begin
            sd_r    <= sd_nxt;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          // Load result once the output register is free
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.sample_count   <= rmv_pkg::COUNT_OUT_W'(count_r);
            out_ch.min_value      <= rmv_pkg::MINMAX_W'(min_r);
            out_ch.max_value      <= rmv_pkg::MINMAX_W'(max_r);
            out_ch.mean_value     <= rmv_pkg::MEAN_W'(mean_r);
            out_ch.variance_value <= var_r;
            out_ch.std_deviation  <= sd_r;
            state_r               <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/rmv_iter_unit.sv =====
// Shared bit-serial unit: restoring divide, shift-add multiply, digit-pair square root
module rmv_iter_unit #(
  parameter int COUNT_WIDTH = rmv_pkg::COUNT_WIDTH_DEF,
  parameter int FRAC_BITS   = rmv_pkg::FRAC_BITS_DEF,
  parameter int MUL_WIDTH   = rmv_pkg::SAMPLE_WIDTH_DEF + rmv_pkg::FRAC_BITS_DEF + 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rmv_pkg::rmv_req_t            req,
  input  logic [rmv_pkg::DATA_W-1:0]   opa,
  input  logic [rmv_pkg::DATA_W-1:0]   opb,
  output logic                         done,
  output logic [rmv_pkg::DATA_W-1:0]   result
);

  localparam int DW  = rmv_pkg::DATA_W;
  localparam int RW  = rmv_pkg::ROOT_W;
  localparam int PW  = 2 * MUL_WIDTH;

  typedef enum logic {U_IDLE, U_RUN} ustate_t;

  ustate_t                         state_r;
  rmv_pkg::rmv_op_t                op_r;
  logic [rmv_pkg::STEP_W-1:0]      step_r;
  logic [DW-1:0]                   x_r, x_nxt;
  logic [COUNT_WIDTH-1:0]          rem_r, rem_nxt, dvs_r;
  logic [PW-1:0]                   acc_r, acc_nxt;
  logic [MUL_WIDTH-1:0]            mcand_r;
  logic [RW-1:0]                   root_r, root_nxt;
  logic [RW+1:0]                   srem_r, srem_nxt;
  logic [DW-1:0]                   res_nxt;

  logic [COUNT_WIDTH:0]            div_sh;
  logic [RW+3:0]                   sq_sh, sq_trial;
  logic [2*DW-1:0]                 prod_sh;

  // One iteration of the selected operation
  always_comb begin
    div_sh   = {rem_r, x_r[DW-1]};
    sq_sh    = {srem_r, x_r[DW-1:DW-2]};
    sq_trial = {2'b00, root_r, 2'b01};
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    acc_nxt  = acc_r;
    root_nxt = root_r;
    srem_nxt = srem_r;
    prod_sh  = '0;
    res_nxt  = '0;
    unique case (op_r)
      rmv_pkg::OP_DIV: begin
        if (div_sh >= {1'b0, dvs_r}) begin
          rem_nxt = COUNT_WIDTH'(div_sh - {1'b0, dvs_r});
          x_nxt   = {x_r[DW-2:0], 1'b1};
        end else begin
          rem_nxt = div_sh[COUNT_WIDTH-1:0];
          x_nxt   = {x_r[DW-2:0], 1'b0};
        end
        res_nxt = x_nxt;
      end
      rmv_pkg::OP_MUL: begin
        acc_nxt = {acc_r[PW-2:0], 1'b0} +
                  (x_r[MUL_WIDTH-1] ? PW'(mcand_r) : PW'(0));
        x_nxt   = {x_r[DW-2:0], 1'b0};
        prod_sh = (2*DW)'(acc_nxt) >> FRAC_BITS;
        res_nxt = (|prod_sh[2*DW-1:DW]) ? '1 : prod_sh[DW-1:0];
      end
      rmv_pkg::OP_SQRT: begin
        if (sq_sh >= sq_trial) begin
          srem_nxt = (RW+2)'(sq_sh - sq_trial);
          root_nxt = {root_r[RW-2:0], 1'b1};
        end else begin
          srem_nxt = sq_sh[RW+1:0];
          root_nxt = {root_r[RW-2:0], 1'b0};
        end
        x_nxt   = {x_r[DW-3:0], 2'b00};
        res_nxt = DW'(root_nxt);
      end
      default: ;
    endcase
  end

  // Sequencing of iterations
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state_r)
        U_IDLE: begin
          if (req.start) begin
            state_r <= U_RUN;
            op_r    <= req.op;
            x_r     <= opb;
            rem_r   <= '0;
            acc_r   <= '0;
            root_r  <= '0;
            srem_r  <= '0;
            dvs_r   <= opa[COUNT_WIDTH-1:0];
            mcand_r <= opa[MUL_WIDTH-1:0];
            unique case (req.op)
              rmv_pkg::OP_DIV:  step_r <= rmv_pkg::STEP_W'(DW - 1);
              rmv_pkg::OP_MUL:  step_r <= rmv_pkg::STEP_W'(MUL_WIDTH - 1);
              rmv_pkg::OP_SQRT: step_r <= rmv_pkg::STEP_W'(RW - 1);
              default:          step_r <= '0;
            endcase
          end
        end
        U_RUN: begin
          x_r    <= x_nxt;
          rem_r  <= rem_nxt;
          acc_r  <= acc_nxt;
          root_r <= root_nxt;
          srem_r <= srem_nxt;
          step_r <= step_r - 1'b1;
          if (step_r == '0) begin
            state_r <= U_IDLE;
            done    <= 1'b1;
            result  <= res_nxt;
          end
        end
        default: state_r <= U_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/running_mean_variance_min_max_unit_checker.sv =====
module running_mean_variance_min_max_unit_checker (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  logic signed [15:0] in_sample,
  input  logic out_valid,
  input  logic out_ready,
  input  logic [31:0] out_sample_count,
  input  logic signed [15:0] out_min_value,
  input  logic signed [15:0] out_max_value,
  input  logic signed [31:0] out_mean_value,
  input  logic [46:0] out_variance_value,
  input  logic [22:0] out_std_deviation,
  output int unsigned fail_count,
  output int unsigned pending_stats,
  output int unsigned results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] cnt;
    logic signed [15:0] mn;
    logic signed [15:0] mx;
    logic signed [31:0] mean;
    logic [46:0] var_q;
    logic [22:0] sd;
  } stats_t;

  stats_t expected_stats[$];

  // running statistics held by the predictor
  longint unsigned n_seen;
  longint mean_acc;
  logic [63:0] sq_dev_sum;
  longint lo_seen, hi_seen;

  function automatic longint unsigned abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // (a*b) >> 16 with saturation to 64 bits
  function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = a * b;
    p = p >> 16;
    if (p[127:64] != 0) return '1;
    return p[63:0];
  endfunction

  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic stats_t fold_sample(logic signed [15:0] s);
    longint x, xq, old_m, new_m;
    logic [63:0] inc, var64, sd64;
    stats_t r;
    x = s;
    xq = x * 65536;
    if (n_seen == 0) begin
      n_seen = 1;
      mean_acc = xq;
      sq_dev_sum = 0;
      lo_seen = x;
      hi_seen = x;
    end else begin
      old_m = mean_acc;
      if (n_seen < 64'hFFFF_FFFF) n_seen++;
      new_m = old_m + (xq - old_m) / longint'(n_seen);
      inc = scaled_product(abs64(xq - old_m), abs64(xq - new_m));
      sq_dev_sum = (sq_dev_sum > ~inc) ? '1 : sq_dev_sum + inc;
      mean_acc = new_m;
      if (x < lo_seen) lo_seen = x;
      if (x > hi_seen) hi_seen = x;
    end
    var64 = sq_dev_sum / n_seen;
    if (var64 > 64'h7FFF_FFFF_FFFF) var64 = 64'h7FFF_FFFF_FFFF;
    sd64 = floor_root(var64);
    if (sd64 > 64'h7F_FFFF) sd64 = 64'h7F_FFFF;
    r.cnt = n_seen[31:0];
    r.mn = lo_seen[15:0];
    r.mx = hi_seen[15:0];
    r.mean = mean_acc[31:0];
    r.var_q = var64[46:0];
    r.sd = sd64[22:0];
    return r;
  endfunction

  assign pending_stats = expected_stats.size();

  // predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    stats_t e;
    if (!rst_n) begin
      n_seen <= 0;
      mean_acc <= 0;
      sq_dev_sum <= 0;
      lo_seen <= 0;
      hi_seen <= 0;
      fail_count <= 0;
      results_seen <= 0;
      expected_stats.delete();
    end else begin
      if (in_valid && in_ready) expected_stats.push_back(fold_sample(in_sample));
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_stats.size() == 0) begin
          $display("%0t: unexpected result transaction count=%0d", $time, out_sample_count);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_stats.pop_front();
          if (e != {out_sample_count, out_min_value, out_max_value, out_mean_value,
                    out_variance_value, out_std_deviation}) begin
            $display("%0t: mismatch exp cnt=%0d min=%0d max=%0d mean=%0h var=%0h sd=%0h",
                     $time, e.cnt, e.mn, e.mx, e.mean, e.var_q, e.sd);
            $display("%0t:          got cnt=%0d min=%0d max=%0d mean=%0h var=%0h sd=%0h",
                     $time, out_sample_count, out_min_value, out_max_value,
                     out_mean_value, out_variance_value, out_std_deviation);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/running_mean_variance_min_max_unit_tb.sv =====
module running_mean_variance_min_max_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst_n = 0;
  int unsigned fail_count, pending_stats, results_seen;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  longint unsigned cycle_cnt = 0;

  rmv_in_if  in_ch();
  rmv_out_if out_ch();

  running_mean_variance_min_max_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  running_mean_variance_min_max_unit_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_sample(in_ch.sample),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_sample_count(out_ch.sample_count), .out_min_value(out_ch.min_value),
    .out_max_value(out_ch.max_value), .out_mean_value(out_ch.mean_value),
    .out_variance_value(out_ch.variance_value), .out_std_deviation(out_ch.std_deviation),
    .fail_count(fail_count), .pending_stats(pending_stats), .results_seen(results_seen)
  );

  always #1 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.sample = 0;
    out_ch.ready = 0;
  end

  // receiver stalls
  always @(posedge clk) out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

  // run limit: ~1300 samples plus stalls
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 3_000_000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // valid stays high only when the next sample follows in the same time step
  task automatic push_sample(logic signed [15:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.sample <= s;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (pending_stats != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // random samples: mostly clustered values, some full-range and extremes
  task automatic random_burst(int n);
    int base;
    base = $urandom_range(65535) - 32768;
    repeat (n) begin
      case ($urandom_range(9))
        0, 1: push_sample(16'($urandom));
        2: push_sample($urandom_range(1) ? 16'sh7FFF : 16'sh8000);
        default: push_sample(16'(base + int'($urandom_range(64)) - 32));
      endcase
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: first sample, extremes, large spread, repeats
    push_sample(16'sh8000);
    push_sample(16'sh7FFF);
    push_sample(16'sh8000);
    push_sample(16'sh7FFF);
    push_sample(16'sh0000);
    push_sample(16'shFFFF);
    push_sample(16'sh0001);
    push_sample(16'sh5555);
    push_sample(16'shAAAA);
    repeat (6) push_sample(16'sh7FFF);
    drain();

    send_idle_pct = 18;
    recv_idle_pct = 81;
    random_burst(430);
    // hold off until every result is back
    drain();
    send_idle_pct = 81;
    recv_idle_pct = 18;
    random_burst(430);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_burst(430);
    drain();

    $display("Covered %0d results: extreme samples, clustered and full-range random data,",
             results_seen);
    $display("with sender and receiver stalls in both ratios and a stall-free stretch.");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
